### hdl/mdfl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdfl_pkg
// Shared constants and types of the motion detector / flash page logger.
// ----------------------------------------------------------------------------
package mdfl_pkg;

    localparam int PAGE_BYTES   = 32;
    localparam int SAMPLE_WIDTH = 16;
    localparam int SMP_W        = 16;
    localparam int ADDR_W       = 24;
    localparam int IDX_W        = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;

    localparam logic [SMP_W-1:0]  SAMPLE_MASK   = SMP_W'((64'd1 << SAMPLE_WIDTH) - 64'd1);
    localparam logic [IDX_W-1:0]  LAST_IDX      = IDX_W'(PAGE_BYTES - 1);
    localparam logic [ADDR_W-1:0] PAGE_STEP     = ADDR_W'(PAGE_BYTES);
    localparam logic [SMP_W-1:0]  THRESH_RESET  = 16'd30;

    localparam logic [7:0] CMD_WREN = 8'h06;
    localparam logic [7:0] CMD_PROG = 8'h02;
    localparam logic [7:0] CMD_WRDI = 8'h04;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // output byte source select
    localparam logic [2:0] SEL_NONE  = 3'd0;
    localparam logic [2:0] SEL_WREN  = 3'd1;
    localparam logic [2:0] SEL_PROG  = 3'd2;
    localparam logic [2:0] SEL_ADDR2 = 3'd3;
    localparam logic [2:0] SEL_ADDR1 = 3'd4;
    localparam logic [2:0] SEL_ADDR0 = 3'd5;
    localparam logic [2:0] SEL_DATA  = 3'd6;
    localparam logic [2:0] SEL_WRDI  = 3'd7;

    typedef struct packed {
        logic             accept;     // input request taken this cycle
        logic             load;       // load output payload register
        logic [2:0]       sel;
        logic             frame_end;
        logic             last;
        logic             page_done;  // advance page address
        logic [IDX_W-1:0] rd_idx;     // buffer read address for next cycle
    } t_cmd;

    typedef struct packed {
        logic page_full;
    } t_status;

endpackage

### hdl/motion_detect_flash_logger.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_detect_flash_logger
// Motion detector on ADC samples with a serial-flash page logger.
// ----------------------------------------------------------------------------
// A timer tick or a sample that does not complete a page is taken and gives
// one result in the registered output stage the cycle after; with the output
// drained, one such request is taken every cycle. The sample that completes a
// 32-byte page gives 38 byte results (write enable, page program with three
// address bytes and the page data, write disable), one per cycle while the
// output is not stalled, from the single output register and the page
// buffer's one read port; no new request is taken until the write disable
// byte is loaded. The motion threshold may be written at any time the block
// is idle and resets to 30.
module motion_detect_flash_logger
    import mdfl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_motion_threshold_we,
    input  logic [SMP_W-1:0] i_motion_threshold,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_operation,
    input  logic [SMP_W-1:0] i_sample,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_motion,
    output logic             o_byte_valid,
    output logic [7:0]       o_flash_byte,
    output logic             o_frame_end,
    output logic             o_last
);

    t_cmd    cmd;
    t_status status;

    mdfl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .i_out_stall (i_stall),
        .i_status    (status),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .o_cmd       (cmd)
    );

    mdfl_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_thr_we     (i_motion_threshold_we),
        .i_thr        (i_motion_threshold),
        .i_operation  (i_operation),
        .i_sample     (i_sample),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_motion     (o_motion),
        .o_byte_valid (o_byte_valid),
        .o_flash_byte (o_flash_byte),
        .o_frame_end  (o_frame_end),
        .o_last       (o_last)
    );

`ifndef SYNTHESIS
    // a result without a flash byte is always the only result of its request
    a_plain_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_byte_valid) |-> o_last)
        else $error("non-byte result without last");

    // the closing byte of a flash sequence is write disable, ending a frame
    a_last_byte_wrdi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_byte_valid && o_last) |-> (o_flash_byte == CMD_WRDI && o_frame_end))
        else $error("flash sequence does not end with write disable");

    // no new request while a result waits in the output stage
    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("input taken while output stage held");

    // the byte stream runs without gaps once its bytes are taken
    a_stream_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_byte_valid && !o_last) |=> o_valid)
        else $error("gap inside flash byte stream");
`endif

endmodule

### hdl/mdfl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdfl_ctrl
// Sequencer: input/output handshake and flash command byte sequence.
// ----------------------------------------------------------------------------
module mdfl_ctrl
    import mdfl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_operation,
    input  logic    i_out_stall,
    input  t_status i_status,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WREN  = 3'd1;
    localparam logic [2:0] ST_PROG  = 3'd2;
    localparam logic [2:0] ST_ADDR2 = 3'd3;
    localparam logic [2:0] ST_ADDR1 = 3'd4;
    localparam logic [2:0] ST_ADDR0 = 3'd5;
    localparam logic [2:0] ST_DATA  = 3'd6;
    localparam logic [2:0] ST_WRDI  = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == ST_IDLE) && out_free);

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        o_cmd         = '0;
        o_cmd.accept  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid && out_free) begin
                    o_cmd.accept = 1'b1;
                    if (i_operation == OP_TICK || !i_status.page_full) begin
                        o_cmd.load = 1'b1;
                        o_cmd.sel  = SEL_NONE;
                        o_cmd.last = 1'b1;
                    end else begin
                        n_state = ST_WREN;
                    end
                end
            end
            ST_WREN: begin
                o_cmd.load      = out_free;
                o_cmd.sel       = SEL_WREN;
                o_cmd.frame_end = 1'b1;
                if (out_free) n_state = ST_PROG;
            end
            ST_PROG: begin
                o_cmd.load = out_free;
                o_cmd.sel  = SEL_PROG;
                if (out_free) n_state = ST_ADDR2;
            end
            ST_ADDR2: begin
                o_cmd.load = out_free;
                o_cmd.sel  = SEL_ADDR2;
                if (out_free) n_state = ST_ADDR1;
            end
            ST_ADDR1: begin
                o_cmd.load = out_free;
                o_cmd.sel  = SEL_ADDR1;
                if (out_free) n_state = ST_ADDR0;
            end
            ST_ADDR0: begin
                o_cmd.load = out_free;
                o_cmd.sel  = SEL_ADDR0;
                if (out_free) n_state = ST_DATA;
            end
            ST_DATA: begin
                o_cmd.load      = out_free;
                o_cmd.sel       = SEL_DATA;
                o_cmd.frame_end = (r_idx == LAST_IDX);
                if (out_free) begin
                    if (r_idx == LAST_IDX) begin
                        n_idx   = '0;
                        n_state = ST_WRDI;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_WRDI: begin
                o_cmd.load      = out_free;
                o_cmd.sel       = SEL_WRDI;
                o_cmd.frame_end = 1'b1;
                o_cmd.last      = 1'b1;
                o_cmd.page_done = out_free;
                if (out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
                n_idx   = '0;
            end
        endcase
        o_cmd.rd_idx = n_idx;
    end

    always_comb begin
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### hdl/mdfl_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdfl_dp
// Datapath: motion compare, page buffer, page address and result register.
// ----------------------------------------------------------------------------
module mdfl_dp
    import mdfl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_thr_we,
    input  logic [SMP_W-1:0] i_thr,
    input  logic             i_operation,
    input  logic [SMP_W-1:0] i_sample,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    output logic             o_motion,
    output logic             o_byte_valid,
    output logic [7:0]       o_flash_byte,
    output logic             o_frame_end,
    output logic             o_last
);

    logic [SMP_W-1:0]  r_thr;
    logic              r_flag, n_flag;
    logic [SMP_W-1:0]  r_prev;
    logic [IDX_W-1:0]  r_fill;
    logic [ADDR_W-1:0] r_addr;
    logic [7:0]        r_page_buf [PAGE_BYTES];
    logic [7:0]        r_rd_data;

    logic              r_o_motion, r_o_byte_valid, r_o_frame_end, r_o_last;
    logic [7:0]        r_o_byte, n_o_byte;

    logic [SMP_W-1:0]  smp;
    logic [SMP_W-1:0]  diff;
    logic              is_sample;

    assign smp       = i_sample & SAMPLE_MASK;
    assign diff      = (smp > r_prev) ? (smp - r_prev) : (r_prev - smp);
    assign is_sample = i_cmd.accept && (i_operation == OP_SAMPLE);

    assign o_status.page_full = (r_fill == LAST_IDX);

    always_comb begin
        n_flag = r_flag;
        if (i_cmd.accept) begin
            if (i_operation == OP_TICK) begin
                n_flag = 1'b0;
            end else if (diff > r_thr) begin
                n_flag = 1'b1;
            end
        end
    end

    always_comb begin
        case (i_cmd.sel)
            SEL_NONE:  n_o_byte = 8'h00;
            SEL_WREN:  n_o_byte = CMD_WREN;
            SEL_PROG:  n_o_byte = CMD_PROG;
            SEL_ADDR2: n_o_byte = r_addr[23:16];
            SEL_ADDR1: n_o_byte = r_addr[15:8];
            SEL_ADDR0: n_o_byte = r_addr[7:0];
            SEL_DATA:  n_o_byte = r_rd_data;
            SEL_WRDI:  n_o_byte = CMD_WRDI;
            default:   n_o_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= THRESH_RESET;
            r_flag <= 1'b0;
            r_prev <= '0;
            r_fill <= '0;
            r_addr <= '0;
        end else begin
            if (i_thr_we) r_thr <= i_thr;
            r_flag <= n_flag;
            if (is_sample) begin
                r_prev <= smp;
                r_fill <= (r_fill == LAST_IDX) ? '0 : r_fill + 1'b1;
            end
            if (i_cmd.page_done) r_addr <= r_addr + PAGE_STEP;
        end
    end

    // page buffer: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (is_sample) r_page_buf[r_fill] <= smp[7:0];
        r_rd_data <= r_page_buf[i_cmd.rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_motion     <= n_flag;
            r_o_byte_valid <= (i_cmd.sel != SEL_NONE);
            r_o_byte       <= n_o_byte;
            r_o_frame_end  <= i_cmd.frame_end;
            r_o_last       <= i_cmd.last;
        end
    end

    assign o_motion     = r_o_motion;
    assign o_byte_valid = r_o_byte_valid;
    assign o_flash_byte = r_o_byte;
    assign o_frame_end  = r_o_frame_end;
    assign o_last       = r_o_last;

endmodule
